### src/sprq_pkg.sv
// package: request and result types, operation and status codes, command struct
`default_nettype none
package sprq_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_POP    = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] process_handle;
		logic [7:0]  priority_req;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] popped_handle;
		logic [7:0]  popped_priority;
		logic [4:0]  entry_count;
		logic        now_empty;
	} result_t;

	typedef struct packed {
		logic capture;
		logic compare;
		logic update;
	} ctrl_cmd_t;

endpackage
`default_nettype wire

### src/sprq_ctrl.sv
// controller: sequences capture, compare and update for one request
`default_nettype none
module sprq_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	output logic                    done,
	output sprq_pkg::ctrl_cmd_t     cmd
);
	import sprq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_COMPARE,
		S_UPDATE
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_COMPARE;
						busy_q  <= 1'b1;
					end
				end
				S_COMPARE: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign cmd.capture = start && !busy_q;
	assign cmd.compare = (state_q == S_COMPARE);
	assign cmd.update  = (state_q == S_UPDATE);

endmodule
`default_nettype wire

### src/sprq_datapath.sv
// datapath: row of entry cells with parallel compare and shift
`default_nettype none
module sprq_datapath #(
	parameter int CAPACITY = sprq_pkg::CAPACITY_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sprq_pkg::ctrl_cmd_t cmd,
	input  wire sprq_pkg::request_t  request,
	output sprq_pkg::result_t        result
);
	import sprq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int LVL   = $clog2(CAPACITY);

	logic [15:0]         handle_q [CAPACITY];
	logic [7:0]          prio_q   [CAPACITY];
	logic [CNT_W-1:0]    count_q;
	request_t            req_q;
	logic [CAPACITY-1:0] ge_s1;
	result_t             result_q;

	logic [CAPACITY-1:0] mark;
	logic [CAPACITY-1:0] pre [LVL+1];
	logic [CAPACITY-1:0] ge;
	logic                full;
	logic                empty;

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	// cells at or after the placement position; prefix or over the first smaller priority
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			mark[i] = (req_q.opcode == OP_INSERT) && (CNT_W'(i) < count_q)
				&& (prio_q[i] < req_q.priority_req);
		end
		pre[0] = mark;
		for (int l = 0; l < LVL; l++) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (i >= (1 << l)) begin
					pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
				end else begin
					pre[l+1][i] = pre[l][i];
				end
			end
		end
		for (int i = 0; i < CAPACITY; i++) begin
			ge[i] = pre[LVL][i] || (CNT_W'(i) >= count_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= request;
		end
		if (cmd.compare) begin
			ge_s1 <= ge;
		end
	end

	logic [CNT_W-1:0] count_next;
	logic [1:0]       status_next;
	logic [15:0]      pop_handle;
	logic [7:0]       pop_prio;
	logic             do_place;
	logic             do_pop;
	logic [31:0]      count_ext;

	always_comb begin
		count_next  = count_q;
		status_next = ST_DONE;
		pop_handle  = '0;
		pop_prio    = '0;
		do_place    = 1'b0;
		do_pop      = 1'b0;
		unique case (req_q.opcode)
			OP_APPEND, OP_INSERT: begin
				if (full) begin
					status_next = ST_FULL;
				end else begin
					do_place   = 1'b1;
					count_next = count_q + 1'b1;
				end
			end
			OP_POP: begin
				if (empty) begin
					status_next = ST_EMPTY;
				end else begin
					do_pop     = 1'b1;
					pop_handle = handle_q[0];
					pop_prio   = prio_q[0];
					count_next = count_q - 1'b1;
				end
			end
			default: begin
				status_next = ST_DONE;
			end
		endcase
		count_ext = 32'(count_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.update) begin
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (do_place) begin
					if (ge_s1[i] && (i == 0 || !ge_s1[(i == 0) ? 0 : i - 1])) begin
						handle_q[i] <= req_q.process_handle;
						prio_q[i]   <= req_q.priority_req;
					end else if (ge_s1[i] && i > 0) begin
						handle_q[i] <= handle_q[(i == 0) ? 0 : i - 1];
						prio_q[i]   <= prio_q[(i == 0) ? 0 : i - 1];
					end
				end else if (do_pop && i < CAPACITY - 1) begin
					handle_q[i] <= handle_q[(i < CAPACITY - 1) ? i + 1 : i];
					prio_q[i]   <= prio_q[(i < CAPACITY - 1) ? i + 1 : i];
				end
			end
			result_q.status          <= status_next;
			result_q.popped_handle   <= pop_handle;
			result_q.popped_priority <= pop_prio;
			result_q.entry_count     <= count_ext[4:0];
			result_q.now_empty       <= (count_next == '0);
		end
	end

	assign result = result_q;

endmodule
`default_nettype wire

### src/stable_priority_ready_queue_core.sv
// top level: stable priority ready queue, controller plus cell datapath
// sequence: the accepting edge captures the request, then COMPARE and UPDATE run; done rises as UPDATE completes
// steps per request: capture, compare and prefix tree, shift update; a new request is taken only while busy is low
// the receiver cannot stall; the result is registered with done and holds until the next request updates it
// reset: arst_n clears the entry count and the controller; cell contents are not reset
`default_nettype none
module stable_priority_ready_queue_core #(
	parameter int CAPACITY = sprq_pkg::CAPACITY_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire sprq_pkg::request_t request,
	output logic                    done,
	output sprq_pkg::result_t       result
);
	import sprq_pkg::*;

	ctrl_cmd_t cmd;

	sprq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	sprq_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.request (request),
		.result  (result)
	);

endmodule
`default_nettype wire
